// ===== rtl/sbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared field types and codes of the sorted-key search table.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int KEY_WIDTH      = 44;
  localparam int POS_WIDTH      = 10;
  localparam int PAY_PORT_WIDTH = 32;
  localparam int COUNT_WIDTH    = 11;

  typedef logic                      kind_t;
  typedef logic [POS_WIDTH-1:0]      pos_t;
  typedef logic [KEY_WIDTH-1:0]      key_t;
  typedef logic [PAY_PORT_WIDTH-1:0] pay_t;
  typedef logic [COUNT_WIDTH-1:0]    count_t;

  // Command kinds.
  localparam kind_t KIND_LOAD   = 1'b0;
  localparam kind_t KIND_LOOKUP = 1'b1;

endpackage

// ===== rtl/sbs_if.sv =====
// ----------------------------------------------------------------------------
// sbs_cmd_if / sbs_res_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface sbs_cmd_if;
  import sbs_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  pos_t  entry_position;
  key_t  key;
  pay_t  payload;

  modport source (output valid, output kind, output entry_position, output key,
                  output payload, input ready);
  modport sink   (input valid, input kind, input entry_position, input key,
                  input payload, output ready);
endinterface

interface sbs_res_if;
  import sbs_pkg::*;

  logic valid;
  logic ready;
  logic found;
  pos_t match_position;
  pay_t match_payload;

  modport source (output valid, output found, output match_position,
                  output match_payload, input ready);
  modport sink   (input valid, input found, input match_position,
                  input match_payload, output ready);
endinterface

// ===== rtl/sbs_ram.sv =====
// ----------------------------------------------------------------------------
// sbs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/sorted_key_binary_search_top.sv =====
// ----------------------------------------------------------------------------
// sorted_key_binary_search_top
// Sorted key table with a binary search engine over two block memories.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries load and lookup words. A load word writes one key and payload
//   at entry_position and gives no result. A lookup word searches the first
//   entry_count entries (the user must write it over cfg_wr_en and cfg_wr_data
//   only while idle, unchecked by the block) and gives one result word on res.
//   The table must be sorted ascending by key for a lookup to be meaningful.
// Probing:
//   The accepting edge of a lookup issues the first probe. Each following
//   cycle compares one key read from the key memory and issues the next
//   probe; a lookup makes up to ceil(log2(n + 1)) probes, fewer on an early
//   hit, and none on an empty table. The single read port of the key memory
//   sets this rate. cmd is ready again in the same cycle that the result
//   enters the output register.
// Reset:
//   entry_count returns to 0 and the output register empties. The memories
//   are not cleared; entries must be loaded before they are searched.
// Stalls:
//   A result waits in the output register while res.ready is low. The engine
//   can finish the next lookup meanwhile and holds that result until the
//   output register frees up; cmd stays not ready during that wait.
// ----------------------------------------------------------------------------
module sorted_key_binary_search_top #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  sbs_pkg::count_t cfg_wr_data,
  sbs_cmd_if.sink         cmd,
  sbs_res_if.source       res
);
  import sbs_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int NW  = (CW > COUNT_WIDTH) ? CW : COUNT_WIDTH;
  localparam int PCW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;

  logic [1:0]  state;
  count_t      entry_count;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] mid;
  key_t        target;

  logic        hold_found;
  pos_t        hold_pos;
  pay_t        hold_pay;

  logic        res_valid;
  logic        res_found;
  pos_t        res_pos;
  pay_t        res_pay;

  logic [CW-1:0] n_sat;
  logic [CW-1:0] mid_first;
  logic [CW-1:0] lo_up;
  logic [CW-1:0] mid_up;
  logic [CW-1:0] mid_down;

  logic                     key_wr_en;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  key_t                     rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  logic [PAYLOAD_WIDTH-1:0] wr_pay;

  logic        cmd_take;
  logic        out_free;
  logic        hit;
  logic        less;
  logic        fin;
  logic        step_found;
  pos_t        step_pos;
  pay_t        step_pay;

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  sbs_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd.key),
    .rd_addr (rd_addr),
    .rd_data (rd_key)
  );

  sbs_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_pay_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_pay),
    .rd_addr (rd_addr),
    .rd_data (rd_pay)
  );

  // --------------------------------------------------------------------------
  // Search arithmetic
  // --------------------------------------------------------------------------
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_take  = cmd.valid && cmd.ready;
  assign out_free  = !res_valid || res.ready;

  // Counts beyond the table are clipped to its depth.
  assign n_sat = (NW'(entry_count) > NW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                        : CW'(entry_count);
  assign mid_first = (n_sat - CW'(1)) >> 1;

  // Both possible next probes are prepared from registers, and the key
  // compare only picks one of them.
  assign lo_up    = mid + CW'(1);
  assign mid_up   = lo_up + ((hi - CW'(1) - lo_up) >> 1);
  assign mid_down = lo + ((mid - CW'(1) - lo) >> 1);

  assign hit  = (rd_key == target);
  assign less = (rd_key < target);
  assign fin  = hit || (less ? !(lo_up < hi) : !(lo < mid));

  assign step_found = hit;
  assign step_pos   = hit ? POS_WIDTH'(mid) : '0;
  assign step_pay   = hit ? PAY_PORT_WIDTH'(rd_pay) : '0;

  assign key_wr_en = cmd_take && (cmd.kind == KIND_LOAD) &&
                     (PCW'(cmd.entry_position) < PCW'(TABLE_DEPTH));
  assign wr_addr   = AW'(cmd.entry_position);
  assign wr_pay    = PAYLOAD_WIDTH'(cmd.payload);

  always_comb begin
    case (state)
      ST_IDLE:   rd_addr = AW'(mid_first);
      ST_SEARCH: rd_addr = less ? AW'(mid_up) : AW'(mid_down);
      default:   rd_addr = AW'(mid);
    endcase
  end

  // --------------------------------------------------------------------------
  // Control and search registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
    end else begin
      if (cfg_wr_en) begin
        entry_count <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_take && (cmd.kind == KIND_LOOKUP)) begin
            if (n_sat == '0) begin
              state <= ST_DONE;
            end else begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (fin) begin
            state <= out_free ? ST_IDLE : ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        lo         <= '0;
        hi         <= n_sat;
        mid        <= mid_first;
        target     <= cmd.key;
        hold_found <= 1'b0;
        hold_pos   <= '0;
        hold_pay   <= '0;
      end
      ST_SEARCH: begin
        if (fin) begin
          hold_found <= step_found;
          hold_pos   <= step_pos;
          hold_pay   <= step_pay;
        end else if (less) begin
          lo  <= lo_up;
          mid <= mid_up;
        end else begin
          hi  <= mid;
          mid <= mid_down;
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == ST_SEARCH) && fin && out_free) begin
      res_valid <= 1'b1;
    end else if ((state == ST_DONE) && out_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_SEARCH) && fin && out_free) begin
      res_found <= step_found;
      res_pos   <= step_pos;
      res_pay   <= step_pay;
    end else if ((state == ST_DONE) && out_free) begin
      res_found <= hold_found;
      res_pos   <= hold_pos;
      res_pay   <= hold_pay;
    end
  end

  assign res.valid          = res_valid;
  assign res.found          = res_found;
  assign res.match_position = res_pos;
  assign res.match_payload  = res_pay;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_interval_open: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (lo < hi))
    else $error("search interval is empty while probing");

  a_mid_inside: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> ((mid >= lo) && (mid < hi)))
    else $error("probe position lies outside the search interval");

  a_interval_shrinks: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SEARCH) && $past(state == ST_SEARCH)) |->
      ((hi - lo) < $past(hi - lo)))
    else $error("search interval did not shrink after a probe");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_SEARCH || $past(state) == ST_DONE))
    else $error("result word appeared without a finished lookup");

endmodule
